/* hdl/afr_pkg.sv */
// Shared types and constants for the audio frame resampler.
// No dependencies; every other file of the block imports this package.
package afr_pkg;

   // Fixed widths of the channel payloads and the control registers.
   localparam int FIELD_W          = 32;
   localparam int FACTOR_REG_W     = 7;
   localparam int CHAN_REG_W       = 2;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 7;

   // Defaults for the top-level parameters.
   localparam int MAX_FACTOR_DEF   = 64;
   localparam int SAMPLE_WIDTH_DEF = 32;

   // Control register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEED_MODE      = 2'd0,
      CSR_RESAMPLE_FACTOR = 2'd1,
      CSR_CHANNEL_COUNT   = 2'd2
   } csr_idx_type;

   // Mode codes held in the speed_mode register.
   localparam logic SPEED_UP  = 1'b0;
   localparam logic SLOW_DOWN = 1'b1;

   // Channel counts of two and above are treated as stereo.
   localparam logic [CHAN_REG_W-1:0] CHAN_STEREO = 2'd2;

   // Raw register contents handed from the top level to the sequencer.
   typedef struct packed {
      logic                    speed_mode;
      logic [FACTOR_REG_W-1:0] resample_factor;
      logic [CHAN_REG_W-1:0]   channel_count;
   } cfg_type;

   // Status of the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* hdl/afr_ifs.sv */
// Valid/ready channel interfaces of the audio frame resampler.
// Depends on afr_pkg for the payload widths.

interface afr_req_if import afr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] sample_first;
   logic signed [FIELD_W-1:0] sample_second;

   modport source (output valid, output sample_first, output sample_second, input ready);
   modport sink   (input valid, input sample_first, input sample_second, output ready);
endinterface

interface afr_rsp_if import afr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] out_first;
   logic signed [FIELD_W-1:0] out_second;
   logic                      run_last;

   modport source (output valid, output out_first, output out_second, output run_last,
                   input ready);
   modport sink   (input valid, input out_first, input out_second, input run_last,
                   output ready);
endinterface

interface afr_csr_if import afr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/audio_frame_resampler_top.sv */
// Top level of the audio frame resampler: control registers and the sequencer.
// Depends on afr_pkg, the channel interfaces in afr_ifs.sv, afr_seq and afr_div.
//
//   Channel    Modport  Moves                           Payload
//   req_chan   sink     one input frame per item        sample_first, sample_second
//   rsp_chan   source   one output frame per item       out_first, out_second, run_last
//   csr_chan   sink     one register write per item     index, data
//
// In speed-up mode a kept item is accepted in the idle state, and its frame is
// then placed in the result register from the final state once that register
// is free. A dropped item is accepted and the sequencer stays idle.
// In slow-down mode the first frame, and every frame at a factor of one, also
// goes straight to the final state. Any later frame passes the prep state, one
// division per channel in the divide states and then the interpolation state.
// The bit-serial divider, which produces one quotient bit per cycle and is
// shared by both channels, works out the step; the interpolated frames then
// leave at one per cycle while the result channel takes them, and the frame
// itself follows from the final state.
// Reset is synchronous and active high; it clears the registers to speed-up
// mode, a factor of one and mono, and forgets the previous frame.
// A stalled result channel holds the interpolate and final states. The final
// frame of an item stays in the result register while the next is already taken.
module audio_frame_resampler_top import afr_pkg::*; #(
   parameter int MAX_FACTOR   = MAX_FACTOR_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   afr_req_if.sink    req_chan,
   afr_rsp_if.source  rsp_chan,
   afr_csr_if.sink    csr_chan
);

   // Control registers. Writes are always taken; the contract guarantees they
   // only arrive while no item is in flight, so the sequencer can read them
   // directly. An index beyond the list is accepted and ignored.
   logic                    speed_mode_ff, speed_mode_in;
   logic [FACTOR_REG_W-1:0] factor_ff, factor_in;
   logic [CHAN_REG_W-1:0]   chan_ff, chan_in;
   cfg_type                 cfg;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      speed_mode_in = speed_mode_ff;
      factor_in     = factor_ff;
      chan_in       = chan_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            CSR_SPEED_MODE: begin
               speed_mode_in = csr_chan.data[0];
            end
            CSR_RESAMPLE_FACTOR: begin
               factor_in = csr_chan.data[FACTOR_REG_W-1:0];
            end
            CSR_CHANNEL_COUNT: begin
               chan_in = csr_chan.data[CHAN_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_mode_ff <= SPEED_UP;
         factor_ff     <= FACTOR_REG_W'(1);
         chan_ff       <= CHAN_REG_W'(1);
      end else begin
         speed_mode_ff <= speed_mode_in;
         factor_ff     <= factor_in;
         chan_ff       <= chan_in;
      end
   end

   assign cfg.speed_mode      = speed_mode_ff;
   assign cfg.resample_factor = factor_ff;
   assign cfg.channel_count   = chan_ff;

   // The sequencer owns the frame state, the shared divider and the result
   // register that parts the input side from the output side.
   afr_seq #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .MAX_FACTOR   (MAX_FACTOR)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

endmodule

/* hdl/afr_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on afr_pkg for the status struct.
module afr_div import afr_pkg::*; #(
   parameter int DW = SAMPLE_WIDTH_DEF,
   parameter int FW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [FW-1:0] divisor,
   output div_stat_type  stat,
   output logic [DW-1:0] quotient,
   output logic [FW-1:0] remainder
);

   localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [FW-1:0]    rem_ff, rem_in;
   logic [FW-1:0]    dvs_ff, dvs_in;

   logic [FW:0]      partial;
   logic [FW:0]      trial;
   logic             fits;

   always_comb begin
      partial = {rem_ff, quo_ff[DW-1]};
      trial   = partial - {1'b0, dvs_ff};
      fits    = partial >= {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DW - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DW-2:0], fits};
         rem_in = fits ? trial[FW-1:0] : partial[FW-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* hdl/afr_seq.sv */
// Sequencer and datapath of the resampler: frame capture, decimation phase,
// interpolation accumulators and the result register. Uses afr_div, afr_pkg.
module afr_seq import afr_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int MAX_FACTOR   = MAX_FACTOR_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   afr_req_if.sink       req,
   afr_rsp_if.source     rsp
);

   localparam int SW      = SAMPLE_WIDTH;
   localparam int EFF_W   = $clog2(MAX_FACTOR + 1);
   localparam int PHASE_W = $clog2(MAX_FACTOR);
   localparam int CMP_W   = (EFF_W > FACTOR_REG_W) ? EFF_W : FACTOR_REG_W;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_PREP   = 6'b000010,
      S_DIV_A  = 6'b000100,
      S_DIV_B  = 6'b001000,
      S_INTERP = 6'b010000,
      S_FINAL  = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic                    slow_ff, slow_in;
   logic                    stereo_ff, stereo_in;
   logic [EFF_W-1:0]        f_ff, f_in;
   logic signed [SW-1:0]    cur1_ff, cur1_in, cur2_ff, cur2_in;
   logic signed [SW-1:0]    prev1_ff, prev1_in, prev2_ff, prev2_in;
   logic                    have_prev_ff, have_prev_in;
   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic                    neg1_ff, neg1_in, neg2_ff, neg2_in;
   logic [SW-1:0]           mag2_ff, mag2_in;
   logic [SW-1:0]           qd1_ff, qd1_in, qd2_ff, qd2_in;
   logic [EFF_W-1:0]        rd1_ff, rd1_in, rd2_ff, rd2_in;
   logic [SW-1:0]           q1_ff, q1_in, q2_ff, q2_in;
   logic [EFF_W-1:0]        r1_ff, r1_in, r2_ff, r2_in;
   logic [EFF_W-1:0]        k_ff, k_in;
   logic                    rv_ff, rv_in;
   logic signed [FIELD_W-1:0] ro1_ff, ro1_in, ro2_ff, ro2_in;
   logic                    rl_ff, rl_in;

   // Effective factor and channel mode from the raw registers.
   logic [CMP_W-1:0]        fac_cmp;
   logic [EFF_W-1:0]        eff;
   logic                    stereo;
   logic signed [SW-1:0]    in1, in2;

   always_comb begin
      fac_cmp = CMP_W'(cfg.resample_factor);
      if (fac_cmp == '0) begin
         fac_cmp = CMP_W'(1);
      end else if (fac_cmp > CMP_W'(MAX_FACTOR)) begin
         fac_cmp = CMP_W'(MAX_FACTOR);
      end
      eff    = EFF_W'(fac_cmp);
      stereo = cfg.channel_count >= CHAN_STEREO;
      in1    = req.sample_first[SW-1:0];
      in2    = stereo ? req.sample_second[SW-1:0] : '0;
   end

   // Differences to the previous frame, split into sign and magnitude.
   logic signed [SW:0]      diff1, diff2, ndiff1, ndiff2;
   logic [SW-1:0]           mag1, mag2;

   always_comb begin
      diff1  = $signed({cur1_ff[SW-1], cur1_ff}) - $signed({prev1_ff[SW-1], prev1_ff});
      diff2  = $signed({cur2_ff[SW-1], cur2_ff}) - $signed({prev2_ff[SW-1], prev2_ff});
      ndiff1 = -diff1;
      ndiff2 = -diff2;
      mag1   = diff1[SW] ? ndiff1[SW-1:0] : diff1[SW-1:0];
      mag2   = diff2[SW] ? ndiff2[SW-1:0] : diff2[SW-1:0];
   end

   // One interpolation step: add the whole and fractional parts of |diff|/f
   // and carry once the fraction reaches the factor.
   logic [EFF_W:0]          rs1, rs2, rt1, rt2;
   logic                    wrap1, wrap2;
   logic [SW-1:0]           q1_next, q2_next;
   logic [EFF_W-1:0]        r1_next, r2_next;
   logic signed [SW:0]      qs1, qs2, sum1, sum2;
   logic signed [SW-1:0]    val1, val2;

   always_comb begin
      rs1     = {1'b0, r1_ff} + {1'b0, rd1_ff};
      rs2     = {1'b0, r2_ff} + {1'b0, rd2_ff};
      rt1     = rs1 - {1'b0, f_ff};
      rt2     = rs2 - {1'b0, f_ff};
      wrap1   = rs1 >= {1'b0, f_ff};
      wrap2   = rs2 >= {1'b0, f_ff};
      r1_next = wrap1 ? rt1[EFF_W-1:0] : rs1[EFF_W-1:0];
      r2_next = wrap2 ? rt2[EFF_W-1:0] : rs2[EFF_W-1:0];
      q1_next = q1_ff + qd1_ff + SW'(wrap1);
      q2_next = q2_ff + qd2_ff + SW'(wrap2);
      qs1     = $signed({1'b0, q1_next});
      qs2     = $signed({1'b0, q2_next});
      sum1    = $signed({prev1_ff[SW-1], prev1_ff}) + (neg1_ff ? -qs1 : qs1);
      sum2    = $signed({prev2_ff[SW-1], prev2_ff}) + (neg2_ff ? -qs2 : qs2);
      val1    = sum1[SW-1:0];
      val2    = stereo_ff ? sum2[SW-1:0] : '0;
   end

   // Shared divider.
   logic                    div_start;
   logic [SW-1:0]           div_dividend;
   div_stat_type            div_stat;
   logic [SW-1:0]           div_quo;
   logic [EFF_W-1:0]        div_rem;

   afr_div #(
      .DW (SW),
      .FW (EFF_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (f_ff),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   logic out_free;
   logic keep;
   logic rsp_load;

   assign out_free = !rv_ff || rsp.ready;
   assign keep     = phase_ff == '0;

   always_comb begin
      state_in     = state_ff;
      slow_in      = slow_ff;
      stereo_in    = stereo_ff;
      f_in         = f_ff;
      cur1_in      = cur1_ff;
      cur2_in      = cur2_ff;
      prev1_in     = prev1_ff;
      prev2_in     = prev2_ff;
      have_prev_in = have_prev_ff;
      phase_in     = phase_ff;
      neg1_in      = neg1_ff;
      neg2_in      = neg2_ff;
      mag2_in      = mag2_ff;
      qd1_in       = qd1_ff;
      qd2_in       = qd2_ff;
      rd1_in       = rd1_ff;
      rd2_in       = rd2_ff;
      q1_in        = q1_ff;
      q2_in        = q2_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      k_in         = k_ff;
      ro1_in       = ro1_ff;
      ro2_in       = ro2_ff;
      rl_in        = rl_ff;
      rsp_load     = 1'b0;
      div_start    = 1'b0;
      div_dividend = mag1;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cur1_in   = in1;
               cur2_in   = in2;
               slow_in   = cfg.speed_mode;
               stereo_in = stereo;
               f_in      = eff;
               if (cfg.speed_mode == SPEED_UP) begin
                  if ((EFF_W'(phase_ff) + EFF_W'(1)) >= eff) begin
                     phase_in = '0;
                  end else begin
                     phase_in = phase_ff + 1'b1;
                  end
                  state_in = keep ? S_FINAL : S_IDLE;
               end else begin
                  state_in = (have_prev_ff && eff != EFF_W'(1)) ? S_PREP : S_FINAL;
               end
            end
         end
         S_PREP: begin
            div_start    = 1'b1;
            div_dividend = mag1;
            neg1_in      = diff1[SW];
            neg2_in      = diff2[SW];
            mag2_in      = mag2;
            // The second channel's step stays zero in mono, so its fraction
            // never leaves the range below the factor.
            qd2_in       = '0;
            rd2_in       = '0;
            q1_in        = '0;
            q2_in        = '0;
            r1_in        = '0;
            r2_in        = '0;
            k_in         = EFF_W'(1);
            state_in     = S_DIV_A;
         end
         S_DIV_A: begin
            if (div_stat.done) begin
               qd1_in = div_quo;
               rd1_in = div_rem;
               if (stereo_ff) begin
                  div_start    = 1'b1;
                  div_dividend = mag2_ff;
                  state_in     = S_DIV_B;
               end else begin
                  state_in = S_INTERP;
               end
            end
         end
         S_DIV_B: begin
            if (div_stat.done) begin
               qd2_in   = div_quo;
               rd2_in   = div_rem;
               state_in = S_INTERP;
            end
         end
         S_INTERP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               ro1_in   = FIELD_W'(val1);
               ro2_in   = FIELD_W'(val2);
               rl_in    = 1'b0;
               q1_in    = q1_next;
               q2_in    = q2_next;
               r1_in    = r1_next;
               r2_in    = r2_next;
               k_in     = k_ff + 1'b1;
               if (k_ff == f_ff - 1'b1) begin
                  state_in = S_FINAL;
               end
            end
         end
         S_FINAL: begin
            if (out_free) begin
               rsp_load = 1'b1;
               ro1_in   = FIELD_W'(cur1_ff);
               ro2_in   = FIELD_W'(cur2_ff);
               rl_in    = 1'b1;
               if (slow_ff == SLOW_DOWN) begin
                  prev1_in     = cur1_ff;
                  prev2_in     = cur2_ff;
                  have_prev_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rv_in = 1'b1;
      end else if (rsp.ready) begin
         rv_in = 1'b0;
      end else begin
         rv_in = rv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         have_prev_ff <= 1'b0;
         phase_ff     <= '0;
         prev1_ff     <= '0;
         prev2_ff     <= '0;
         rv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         phase_ff     <= phase_in;
         prev1_ff     <= prev1_in;
         prev2_ff     <= prev2_in;
         rv_ff        <= rv_in;
      end
      slow_ff   <= slow_in;
      stereo_ff <= stereo_in;
      f_ff      <= f_in;
      cur1_ff   <= cur1_in;
      cur2_ff   <= cur2_in;
      neg1_ff   <= neg1_in;
      neg2_ff   <= neg2_in;
      mag2_ff   <= mag2_in;
      qd1_ff    <= qd1_in;
      qd2_ff    <= qd2_in;
      rd1_ff    <= rd1_in;
      rd2_ff    <= rd2_in;
      q1_ff     <= q1_in;
      q2_ff     <= q2_in;
      r1_ff     <= r1_in;
      r2_ff     <= r2_in;
      k_ff      <= k_in;
      ro1_ff    <= ro1_in;
      ro2_ff    <= ro2_in;
      rl_ff     <= rl_in;
   end

   assign req.ready      = state_ff == S_IDLE;
   assign rsp.valid      = rv_ff;
   assign rsp.out_first  = ro1_ff;
   assign rsp.out_second = ro2_ff;
   assign rsp.run_last   = rl_ff;

   // The divider is never restarted while it is still working.
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // Division results only arrive while the sequencer waits for them.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIV_A || state_ff == S_DIV_B))
      else $error("divider result arrived outside a divide state");

   // The interpolation index stays within one to factor minus one.
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INTERP) |-> (k_ff != '0 && k_ff < f_ff))
      else $error("interpolation index out of range");

   // The fractional accumulators stay below the factor.
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INTERP) |-> (r1_ff < f_ff && r2_ff < f_ff))
      else $error("fraction accumulator reached the factor");

   // Loading the final frame of an item returns the sequencer to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rl_in) |=> (state_ff == S_IDLE))
      else $error("final frame loaded without returning to idle");

endmodule
